>>> design/bidi_lss_pkg.sv
// Shared types and constants for the bidi line segment splitter.
// Holds the beat structs, state struct and class/kind codes; no dependencies.
package bidi_lss_pkg;

   localparam int POSITION_BITS = 16;
   localparam int RANGE_BITS    = POSITION_BITS + 1;

   localparam logic [2:0] CLS_WS      = 3'd1;
   localparam logic [2:0] CLS_S       = 3'd2;
   localparam logic [2:0] CLS_B       = 3'd3;
   localparam logic [2:0] CLS_REMOVED = 3'd4;

   localparam logic [1:0] KIND_BODY  = 2'd0;
   localparam logic [1:0] KIND_TAIL  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [1:0] QUEUE_DEPTH = 2'd2;

   typedef struct packed {
      logic                     mode;
      logic [2:0]               char_class;
      logic [POSITION_BITS-1:0] position;
   } req_type;

   typedef struct packed {
      logic [1:0]            result_kind;
      logic [RANGE_BITS-1:0] range_start;
      logic [RANGE_BITS-1:0] range_end;
      logic                  ends_at_separator;
      logic                  last;
   } rsp_type;

   // offsets carry a valid flag; cleared flag means "none"
   typedef struct packed {
      logic                  head_vld;
      logic [RANGE_BITS-1:0] head;
      logic                  end_vld;
      logic [RANGE_BITS-1:0] seg_end;
      logic                  space_vld;
      logic [RANGE_BITS-1:0] space;
      logic                  after_sep;
   } line_state_type;

   typedef struct packed {
      line_state_type next;
      logic [1:0]     count;
      rsp_type        r0;
      rsp_type        r1;
   } step_type;

endpackage

>>> design/bidi_lss_core.sv
// Combinational segment logic: next line state and up to two result beats.
// Depends on bidi_lss_pkg.
module bidi_lss_core (
   input  bidi_lss_pkg::line_state_type cur,
   input  bidi_lss_pkg::req_type        item,
   input  logic                         right_to_left,
   output bidi_lss_pkg::step_type       step
);

   localparam int RB = bidi_lss_pkg::RANGE_BITS;

   logic [RB-1:0]                  pos;
   logic [RB-1:0]                  pos_inc;
   bidi_lss_pkg::line_state_type   s;
   bidi_lss_pkg::rsp_type          r0;
   bidi_lss_pkg::rsp_type          r1;
   logic [1:0]                     n;

   assign pos     = {1'b0, item.position};
   assign pos_inc = pos + {{(RB-1){1'b0}}, 1'b1};

   function automatic bidi_lss_pkg::rsp_type mk(
      input logic [1:0] kind, input logic [RB-1:0] a, input logic [RB-1:0] b, input logic sep
   );
      bidi_lss_pkg::rsp_type r;
      r.result_kind       = kind;
      r.range_start       = a;
      r.range_end         = b;
      r.ends_at_separator = sep;
      r.last              = 1'b0;
      return r;
   endfunction

   always_comb begin
      s  = cur;
      n  = 2'd0;
      r0 = mk(bidi_lss_pkg::KIND_BODY, pos, pos, 1'b0);
      r1 = r0;
      if (item.mode) begin
         if (!right_to_left) begin
            if (!s.head_vld) begin
               s.head_vld  = 1'b1;
               s.head      = pos;
               s.space_vld = 1'b0;
            end
            if (!s.space_vld) begin
               s.space = pos;
            end
            r0 = mk(bidi_lss_pkg::KIND_BODY, s.head, s.space, 1'b0);
            r1 = mk(bidi_lss_pkg::KIND_TAIL, s.space, pos, 1'b0);
         end else begin
            if (!s.end_vld) begin
               s.seg_end   = pos_inc;
               s.space_vld = 1'b0;
            end
            if (!s.head_vld) begin
               s.head = pos;
            end
            if (!s.space_vld) begin
               s.space = s.head;
            end
            r0 = mk(bidi_lss_pkg::KIND_TAIL, s.space, s.seg_end, s.after_sep);
            r1 = mk(bidi_lss_pkg::KIND_BODY, s.head, s.space, 1'b0);
         end
         n           = 2'd2;
         s.head_vld  = 1'b0;
         s.end_vld   = 1'b0;
         s.space_vld = 1'b0;
         s.after_sep = 1'b0;
      end else if (item.char_class == bidi_lss_pkg::CLS_B) begin
         r0          = mk(bidi_lss_pkg::KIND_ERROR, pos, pos, 1'b0);
         n           = 2'd1;
         s.head_vld  = 1'b0;
         s.end_vld   = 1'b0;
         s.space_vld = 1'b0;
         s.after_sep = 1'b0;
      end else if (!right_to_left) begin
         if (!s.head_vld) begin
            s.head_vld  = 1'b1;
            s.head      = pos;
            s.space_vld = 1'b0;
         end
         if (item.char_class == bidi_lss_pkg::CLS_S) begin
            if (!s.space_vld) begin
               s.space = pos;
            end
            r0          = mk(bidi_lss_pkg::KIND_BODY, s.head, s.space, 1'b0);
            r1          = mk(bidi_lss_pkg::KIND_TAIL, s.space, pos, 1'b1);
            n           = 2'd2;
            s.head_vld  = 1'b0;
            s.space_vld = 1'b0;
         end else if (item.char_class == bidi_lss_pkg::CLS_WS) begin
            if (!s.space_vld) begin
               s.space_vld = 1'b1;
               s.space     = pos;
            end
         end else if (item.char_class != bidi_lss_pkg::CLS_REMOVED) begin
            s.space_vld = 1'b0;
         end
      end else begin
         if (!s.end_vld) begin
            s.end_vld   = 1'b1;
            s.seg_end   = pos_inc;
            s.space_vld = 1'b0;
         end
         if (item.char_class == bidi_lss_pkg::CLS_S) begin
            if (!s.head_vld) begin
               s.head = pos_inc;
            end
            if (!s.space_vld) begin
               s.space = pos_inc;
            end
            r0          = mk(bidi_lss_pkg::KIND_TAIL, s.space, s.seg_end, s.after_sep);
            r1          = mk(bidi_lss_pkg::KIND_BODY, s.head, s.space, 1'b0);
            n           = 2'd2;
            s.seg_end   = pos;
            s.head_vld  = 1'b0;
            s.space_vld = 1'b0;
            s.after_sep = 1'b1;
         end else if (item.char_class == bidi_lss_pkg::CLS_WS) begin
            if (!s.head_vld || s.head > pos) begin
               s.head_vld = 1'b1;
               s.head     = pos;
            end
         end else if (item.char_class == bidi_lss_pkg::CLS_REMOVED) begin
            if (s.head_vld && s.head > pos) begin
               s.head = pos;
            end
         end else begin
            if (!s.space_vld) begin
               s.space_vld = 1'b1;
               s.space     = pos_inc;
            end
            s.head_vld = 1'b1;
            s.head     = pos;
         end
      end
      if (n == 2'd2) begin
         r1.last = 1'b1;
      end else begin
         r0.last = 1'b1;
      end
      step.next  = s;
      step.count = n;
      step.r0    = r0;
      step.r1    = r1;
   end

endmodule

>>> design/bidi_lss_outq.sv
// Two-entry result queue between the segment logic and the rsp channel.
// Depends on bidi_lss_pkg.
module bidi_lss_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_n,
   input  bidi_lss_pkg::rsp_type push0,
   input  bidi_lss_pkg::rsp_type push1,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output bidi_lss_pkg::rsp_type rsp_data,
   output logic [1:0]            count
);

   bidi_lss_pkg::rsp_type q_ff [2];
   bidi_lss_pkg::rsp_type q_in [2];
   logic [1:0]            count_ff;
   logic [1:0]            count_in;
   logic [1:0]            count_pop;
   logic                  pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = q_ff[0];
   assign count     = count_ff;
   assign pop       = rsp_valid && !rsp_stall;
   assign count_pop = count_ff - {1'b0, pop};
   assign count_in  = count_pop + push_n;

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push_n != 2'd0) begin
         if (count_pop == 2'd0) begin
            q_in[0] = push0;
         end else begin
            q_in[1] = push0;
         end
      end
      if (push_n == 2'd2) begin
         q_in[1] = push1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> design/bidi_line_segment_splitter.sv
// Top level of the bidi rule L1 line segment splitter.
// Depends on bidi_lss_pkg, bidi_lss_core and bidi_lss_outq.
//
//   channel  direction  handshake            beat
//   req      in         req_valid/req_stall  req_data (mode, char_class, position)
//   rsp      out        rsp_valid/rsp_stall  rsp_data (kind, start, end, sep, last)
//   csr      in         csr_valid/csr_ready  csr_data (right_to_left)
//
// One req beat per cycle while req_stall is low; a beat is registered in the
// input register, then its results land in a two-entry queue that feeds rsp.
// A beat that closes a segment yields two rsp beats and holds the input
// register until the queue is down to its last beat being taken; rsp stalls
// reach req_stall once the queue lacks room for the registered beat's results.
// Reset clears line state flags, queue and right_to_left; csr_ready is always high.
module bidi_line_segment_splitter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bidi_lss_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bidi_lss_pkg::rsp_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data
);

   logic                         rtl_ff;
   logic                         st_valid_ff;
   logic                         st_valid_in;
   bidi_lss_pkg::req_type        st_req_ff;
   bidi_lss_pkg::line_state_type line_ff;
   bidi_lss_pkg::line_state_type line_in;
   bidi_lss_pkg::step_type       step;
   logic [1:0]                   q_count;
   logic [1:0]                   q_free;
   logic                         q_pop;
   logic [1:0]                   push_n;
   logic                         st_go;
   logic                         req_take;

   assign csr_ready = 1'b1;
   assign q_pop     = rsp_valid && !rsp_stall;
   assign q_free    = bidi_lss_pkg::QUEUE_DEPTH - q_count + {1'b0, q_pop};
   assign st_go     = st_valid_ff && (q_free >= step.count);
   assign req_stall = st_valid_ff && !st_go;
   assign req_take  = req_valid && !req_stall;
   assign push_n    = st_go ? step.count : 2'd0;

   always_comb begin
      st_valid_in = st_valid_ff;
      if (req_take) begin
         st_valid_in = 1'b1;
      end else if (st_go) begin
         st_valid_in = 1'b0;
      end
      line_in = st_go ? step.next : line_ff;
   end

   bidi_lss_core u_core (
      .cur           (line_ff),
      .item          (st_req_ff),
      .right_to_left (rtl_ff),
      .step          (step)
   );

   bidi_lss_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push0     (step.r0),
      .push1     (step.r1),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .count     (q_count)
   );

   always_ff @(posedge clock) begin
      if (req_take) begin
         st_req_ff <= req_data;
      end
      line_ff.head    <= line_in.head;
      line_ff.seg_end <= line_in.seg_end;
      line_ff.space   <= line_in.space;
      if (reset) begin
         rtl_ff            <= 1'b0;
         st_valid_ff       <= 1'b0;
         line_ff.head_vld  <= 1'b0;
         line_ff.end_vld   <= 1'b0;
         line_ff.space_vld <= 1'b0;
         line_ff.after_sep <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            rtl_ff <= csr_data;
         end
         st_valid_ff       <= st_valid_in;
         line_ff.head_vld  <= line_in.head_vld;
         line_ff.end_vld   <= line_in.end_vld;
         line_ff.space_vld <= line_in.space_vld;
         line_ff.after_sep <= line_in.after_sep;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= bidi_lss_pkg::QUEUE_DEPTH)
      else $error("result queue overfilled");

   a_pair_needs_room: assert property (@(posedge clock) disable iff (reset)
      st_go && step.count == 2'd2 |-> q_count == {1'b0, q_pop})
      else $error("two-beat close issued without a draining queue");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == bidi_lss_pkg::KIND_ERROR |-> rsp_data.last)
      else $error("error beat without last");

   a_body_no_sep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == bidi_lss_pkg::KIND_BODY
         |-> !rsp_data.ends_at_separator)
      else $error("body beat flagged as separator close");

endmodule
